@@ design/tsca_pkg.sv @@
// ============================================================================
// tsca_pkg - shared types and constants for two-step chromatic adaptation
// Widths, matrix coefficient tables, payload words and control structs.
// ============================================================================
`default_nettype none

package tsca_pkg;

    localparam int PIX_W          = 20;
    localparam int OUT_W          = 24;
    localparam int CFG_W          = 60;
    localparam int DEG_W          = 17;
    localparam int DEG_FRAC       = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int COEF_FRAC_BITS = 14;   // coefficient table below is Q2.14
    localparam int GAIN_FRAC_BITS = 16;
    localparam int COEF_W         = 16;
    localparam int CONE_W         = 23;
    localparam int GAIN_W         = GAIN_FRAC_BITS + 13;
    localparam int DIV_NUM_W      = 52;
    localparam int DIV_DEN_W      = GAIN_W;

    localparam logic signed [63:0] GAIN_LIM64 =
        (64'sd1 <<< (GAIN_FRAC_BITS + 12)) - 64'sd1;
    localparam logic signed [GAIN_W-1:0] GAIN_LIM = GAIN_LIM64[GAIN_W-1:0];
    localparam logic signed [63:0] OUT_MAX64 = 64'sd8388607;
    localparam logic signed [63:0] OUT_MIN64 = -64'sd8388608;
    localparam logic [DEG_W-1:0] DEG_FULL = DEG_W'(65536);

    // [mode][forward, inverse][row][col]
    localparam logic signed [COEF_W-1:0] COEF_TAB [2][2][3][3] = '{
        '{
            '{ '{16'sd12006, 16'sd7039, -16'sd2661},
               '{-16'sd11528, 16'sd27812, 16'sd100},
               '{16'sd49, 16'sd223, 16'sd16112} },
            '{ '{16'sd17959, -16'sd4569, 16'sd2994},
               '{16'sd7444, 16'sd7758, 16'sd1181},
               '{-16'sd158, -16'sd93, 16'sd16635} }
        },
        '{
            '{ '{16'sd6575, 16'sd10652, -16'sd843},
               '{-16'sd4100, 16'sd19733, 16'sd751},
               '{-16'sd34, 16'sd802, 16'sd15616} },
            '{ '{16'sd30508, -16'sd16568, 16'sd2444},
               '{16'sd6349, 16'sd10182, -16'sd147},
               '{-16'sd260, -16'sd559, 16'sd17203} }
        }
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE       = 3'd0,
        REG_SRC_WHITE  = 3'd1,
        REG_TGT_WHITE  = 3'd2,
        REG_BASE_WHITE = 3'd3,
        REG_SRC_DEG    = 3'd4,
        REG_TGT_DEG    = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        GS_CONE,
        GS_RY_ISSUE,
        GS_RY_WAIT,
        GS_T_MUL,
        GS_T_DIV,
        GS_T_WAIT,
        GS_A_MUL,
        GS_A_ADD,
        GS_G_DIV,
        GS_G_WAIT,
        GS_DONE
    } gain_state_t;

    typedef struct packed {
        logic [PIX_W-1:0] x_in;
        logic [PIX_W-1:0] y_in;
        logic [PIX_W-1:0] z_in;
    } pix_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] x_out;
        logic signed [OUT_W-1:0] y_out;
        logic signed [OUT_W-1:0] z_out;
        logic                    range_flag;
    } pix_out_t;

    typedef struct packed {
        logic             mode;
        logic [CFG_W-1:0] src_white;
        logic [CFG_W-1:0] tgt_white;
        logic [CFG_W-1:0] base_white;
        logic [DEG_W-1:0] src_deg;
        logic [DEG_W-1:0] tgt_deg;
    } cfg_t;

    typedef struct packed {
        logic                   ready;
        logic                   flag;
        logic [2:0][GAIN_W-1:0] gain;
    } gain_set_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

    function automatic logic signed [COEF_W-1:0] coef(input logic mode, input logic inv,
                                                      input logic [1:0] r,
                                                      input logic [1:0] c);
        return COEF_TAB[mode][inv][r][c];
    endfunction

    // right shift with round to nearest, ties away from zero
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] x,
                                                       input int unsigned sh);
        logic signed [63:0] half;
        logic signed [63:0] bias;
        half = 64'sd1 <<< (sh - 1);
        bias = x[63] ? 64'sd1 : 64'sd0;
        return (x + half - bias) >>> sh;
    endfunction

endpackage

`default_nettype wire

@@ design/two_step_chromatic_adaptation_unit.sv @@
// ============================================================================
// two_step_chromatic_adaptation_unit - von Kries adaptation through a baseline
// Top level: register file, gain sequencer and pixel pipeline.
// ============================================================================
// Usage
//   Input channel: drive pixel (X, Y, Z, unsigned Q12.8) with start high; the
//   word is taken on a rising edge where start is high and busy is low. One
//   word per clock is taken while busy stays low.
//   Result channel: result (X, Y, Z signed Q15.8 plus range_flag) is shown
//   for exactly one cycle with done high.
//   The receiver cannot stall; results leave in input order.
//   Config: cfg_we, cfg_index, cfg_data write one register per edge. The
//   user must write only while no pixel is in flight; the block does not
//   enforce it. Index 0 mode, 1..3 source/target/baseline white, 4..5
//   source/target degree. After reset and after every register write, busy
//   stays high while the gain sequencer rebuilds the three channel gains
//   with eleven passes of the 52-step shared divider when every divide runs
//   (a zero divisor skips its divide), white cone products on the shared
//   multiplier and 18 multiply/add steps. Reset restores the documented
//   register defaults and empties the pipeline.
// ============================================================================
`default_nettype none

module two_step_chromatic_adaptation_unit
    import tsca_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire pix_in_t              pixel,
    output logic                      done,
    output pix_out_t                  result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // configuration registers
    logic             mode_reg;
    logic [CFG_W-1:0] src_white_reg;
    logic [CFG_W-1:0] tgt_white_reg;
    logic [CFG_W-1:0] base_white_reg;
    logic [DEG_W-1:0] src_deg_reg;
    logic [DEG_W-1:0] tgt_deg_reg;

    cfg_t      cfg;
    gain_set_t gains;
    logic      accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b1;
            src_white_reg  <= '0;
            tgt_white_reg  <= '0;
            base_white_reg <= '0;
            src_deg_reg    <= DEG_FULL;
            tgt_deg_reg    <= DEG_FULL;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_MODE:       mode_reg       <= cfg_data[0];
                REG_SRC_WHITE:  src_white_reg  <= cfg_data;
                REG_TGT_WHITE:  tgt_white_reg  <= cfg_data;
                REG_BASE_WHITE: base_white_reg <= cfg_data;
                REG_SRC_DEG:    src_deg_reg    <= cfg_data[DEG_W-1:0];
                REG_TGT_DEG:    tgt_deg_reg    <= cfg_data[DEG_W-1:0];
                default:        ;  // unmapped index, ignored
            endcase
        end
    end

    assign cfg.mode       = mode_reg;
    assign cfg.src_white  = src_white_reg;
    assign cfg.tgt_white  = tgt_white_reg;
    assign cfg.base_white = base_white_reg;
    assign cfg.src_deg    = src_deg_reg;
    assign cfg.tgt_deg    = tgt_deg_reg;

    // gains are stale from the write edge until the sequencer finishes
    tsca_gain u_gain (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_we),
        .cfg     (cfg),
        .gains   (gains)
    );

    assign busy   = !gains.ready;
    assign accept = start && !busy;

    tsca_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .pix       (pixel),
        .mode      (mode_reg),
        .gains     (gains),
        .out_valid (done),
        .res       (result)
    );

endmodule

`default_nettype wire

@@ design/tsca_div.sv @@
// ============================================================================
// tsca_div - iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulse at the end.
// ============================================================================
`default_nettype none

module tsca_div
    import tsca_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;

    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;
    logic [DIV_DEN_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= CNT_W'(DIV_NUM_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;

endmodule

`default_nettype wire

@@ design/tsca_gain.sv @@
// ============================================================================
// tsca_gain - channel gain sequencer
// Recomputes white cone responses, adaptation factors and gains after
// reset and after every register write, on one multiplier and one divider.
// ============================================================================
`default_nettype none

module tsca_gain
    import tsca_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic restart,
    input  wire cfg_t cfg,
    output gain_set_t gains
);

    localparam int MB_W  = 24;
    localparam int MUL_W = GAIN_W + MB_W;
    localparam int ACC_W = COEF_W + PIX_W + 3;

    gain_state_t state_reg, state_next;
    logic [1:0] w_reg, w_next;
    logic [1:0] r_reg, r_next;
    logic [2:0] c_reg, c_next;
    logic       side_reg, side_next;
    logic [1:0] k_reg, k_next;
    logic       flag_reg, flag_next;
    logic       neg_reg, neg_next;

    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [MUL_W-1:0]  mul_reg;
    logic signed [CONE_W-1:0] cone_reg [3][3];
    logic signed [CONE_W-1:0] cone_next [3][3];
    logic signed [GAIN_W-1:0] ry_reg [2];
    logic signed [GAIN_W-1:0] ry_next [2];
    logic signed [GAIN_W-1:0] a_reg [2];
    logic signed [GAIN_W-1:0] a_next [2];
    logic signed [GAIN_W-1:0] gain_reg [3];
    logic signed [GAIN_W-1:0] gain_next [3];
    logic signed [GAIN_W-1:0] t_reg, t_next;

    logic [PIX_W-1:0]         wh [3][3];
    logic [1:0]               cidx;
    logic signed [GAIN_W-1:0] mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic [PIX_W-1:0]         yo, yw;
    logic signed [CONE_W-1:0] cw_sel, co_sel;
    logic [DEG_W-1:0]         dd_sel;
    logic signed [MUL_W-1:0]  p_neg;
    logic [MUL_W-1:0]         p_mag;
    logic [CONE_W-1:0]        cw_mag;
    logic [GAIN_W-1:0]        as_mag, at_mag;
    logic signed [63:0]       cone_rnd, term_c, a_sum;
    logic signed [GAIN_W-1:0] a_sat;
    logic                     a_ovf;
    logic                     q_ovf;
    logic                     q_neg;
    logic signed [GAIN_W-1:0] q_sat;

    div_req_t div_req;
    div_rsp_t div_rsp;

    tsca_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            wh[0][c] = cfg.src_white[PIX_W*c +: PIX_W];
            wh[1][c] = cfg.tgt_white[PIX_W*c +: PIX_W];
            wh[2][c] = cfg.base_white[PIX_W*c +: PIX_W];
        end
    end

    assign cidx   = (c_reg < 3'd3) ? c_reg[1:0] : 2'd2;
    assign yo     = wh[2][1];
    assign yw     = wh[{1'b0, side_reg}][1];
    assign cw_sel = cone_reg[{1'b0, side_reg}][k_reg];
    assign co_sel = cone_reg[2][k_reg];
    assign dd_sel = side_reg ? cfg.tgt_deg : cfg.src_deg;

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            GS_CONE:
            begin
                mul_a = GAIN_W'(coef(cfg.mode, 1'b0, r_reg, cidx));
                mul_b = $signed({{(MB_W-PIX_W){1'b0}}, wh[w_reg][cidx]});
            end
            GS_T_MUL:
            begin
                mul_a = ry_reg[side_reg];
                mul_b = MB_W'(co_sel);
            end
            GS_A_MUL:
            begin
                mul_a = t_reg;
                mul_b = $signed({{(MB_W-DEG_W){1'b0}}, dd_sel});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
    end

    // magnitudes and rounding helpers
    always_comb
    begin
        p_neg    = -mul_reg;
        p_mag    = mul_reg[MUL_W-1] ? p_neg : mul_reg;
        cw_mag   = cw_sel[CONE_W-1] ? -cw_sel : cw_sel;
        as_mag   = a_reg[0][GAIN_W-1] ? -a_reg[0] : a_reg[0];
        at_mag   = a_reg[1][GAIN_W-1] ? -a_reg[1] : a_reg[1];
        cone_rnd = round_shift(64'(acc_reg), COEF_FRAC_BITS);
        term_c   = (64'sd65536 - $signed({{(64-DEG_W){1'b0}}, dd_sel})) <<< GAIN_FRAC_BITS;
        a_sum    = round_shift(64'(mul_reg), DEG_FRAC) + round_shift(term_c, DEG_FRAC);
        a_ovf    = 1'b1;
        if (a_sum > GAIN_LIM64)
            a_sat = GAIN_LIM;
        else if (a_sum < -GAIN_LIM64)
            a_sat = -GAIN_LIM;
        else
        begin
            a_sat = a_sum[GAIN_W-1:0];
            a_ovf = 1'b0;
        end
        q_neg = (state_reg == GS_RY_WAIT) ? 1'b0 : neg_reg;
        q_ovf = div_rsp.quo > DIV_NUM_W'(GAIN_LIM);
        q_sat = q_ovf ? GAIN_LIM : $signed(div_rsp.quo[GAIN_W-1:0]);
        if (q_neg)
            q_sat = -q_sat;
    end

    always_comb
    begin
        state_next = state_reg;
        w_next     = w_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        side_next  = side_reg;
        k_next     = k_reg;
        flag_next  = flag_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        t_next     = t_reg;
        cone_next  = cone_reg;
        ry_next    = ry_reg;
        a_next     = a_reg;
        gain_next  = gain_reg;
        div_req    = '0;

        case (state_reg)
            GS_CONE:
            begin
                if (c_reg != 3'd0 && c_reg != 3'd4)
                    acc_next = ((c_reg == 3'd1) ? '0 : acc_reg)
                             + $signed(mul_reg[ACC_W-1:0]);
                if (c_reg == 3'd4)
                begin
                    cone_next[w_reg][r_reg] = cone_rnd[CONE_W-1:0];
                    c_next = 3'd0;
                    if (r_reg == 2'd2)
                    begin
                        r_next = 2'd0;
                        if (w_reg == 2'd2)
                        begin
                            w_next     = 2'd0;
                            side_next  = 1'b0;
                            state_next = GS_RY_ISSUE;
                        end
                        else
                            w_next = w_reg + 2'd1;
                    end
                    else
                        r_next = r_reg + 2'd1;
                end
                else
                    c_next = c_reg + 3'd1;
            end
            GS_RY_ISSUE:
            begin
                if (yo == '0)
                begin
                    ry_next[side_reg] = GAIN_LIM;
                    flag_next = 1'b1;
                    if (!side_reg)
                        side_next = 1'b1;
                    else
                    begin
                        side_next  = 1'b0;
                        k_next     = 2'd0;
                        state_next = GS_T_MUL;
                    end
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = (DIV_NUM_W'(yw) << GAIN_FRAC_BITS)
                                  + DIV_NUM_W'(yo >> 1);
                    div_req.den   = DIV_DEN_W'(yo);
                    state_next    = GS_RY_WAIT;
                end
            end
            GS_RY_WAIT:
            begin
                if (div_rsp.done)
                begin
                    ry_next[side_reg] = q_sat;
                    flag_next = flag_reg | q_ovf;
                    if (!side_reg)
                    begin
                        side_next  = 1'b1;
                        state_next = GS_RY_ISSUE;
                    end
                    else
                    begin
                        side_next  = 1'b0;
                        k_next     = 2'd0;
                        state_next = GS_T_MUL;
                    end
                end
            end
            GS_T_MUL:
            begin
                state_next = GS_T_DIV;
            end
            GS_T_DIV:
            begin
                if (cw_sel == '0)
                begin
                    t_next     = GAIN_LIM;
                    flag_next  = 1'b1;
                    state_next = GS_A_MUL;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = p_mag[DIV_NUM_W-1:0] + DIV_NUM_W'(cw_mag >> 1);
                    div_req.den   = DIV_DEN_W'(cw_mag);
                    neg_next      = mul_reg[MUL_W-1] ^ cw_sel[CONE_W-1];
                    state_next    = GS_T_WAIT;
                end
            end
            GS_T_WAIT:
            begin
                if (div_rsp.done)
                begin
                    t_next     = q_sat;
                    flag_next  = flag_reg | q_ovf;
                    state_next = GS_A_MUL;
                end
            end
            GS_A_MUL:
            begin
                state_next = GS_A_ADD;
            end
            GS_A_ADD:
            begin
                a_next[side_reg] = a_sat;
                flag_next = flag_reg | a_ovf;
                if (!side_reg)
                begin
                    side_next  = 1'b1;
                    state_next = GS_T_MUL;
                end
                else
                    state_next = GS_G_DIV;
            end
            GS_G_DIV:
            begin
                if (a_reg[1] == '0)
                begin
                    gain_next[k_reg] = GAIN_LIM;
                    flag_next = 1'b1;
                    side_next = 1'b0;
                    if (k_reg == 2'd2)
                        state_next = GS_DONE;
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = GS_T_MUL;
                    end
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = (DIV_NUM_W'(as_mag) << GAIN_FRAC_BITS)
                                  + DIV_NUM_W'(at_mag >> 1);
                    div_req.den   = at_mag;
                    neg_next      = a_reg[0][GAIN_W-1] ^ a_reg[1][GAIN_W-1];
                    state_next    = GS_G_WAIT;
                end
            end
            GS_G_WAIT:
            begin
                if (div_rsp.done)
                begin
                    gain_next[k_reg] = q_sat;
                    flag_next = flag_reg | q_ovf;
                    side_next = 1'b0;
                    if (k_reg == 2'd2)
                        state_next = GS_DONE;
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = GS_T_MUL;
                    end
                end
            end
            GS_DONE:
            begin
                state_next = GS_DONE;
            end
            default:
            begin
                state_next = GS_CONE;
            end
        endcase

        if (restart)
        begin
            state_next = GS_CONE;
            w_next     = 2'd0;
            r_next     = 2'd0;
            c_next     = 3'd0;
            side_next  = 1'b0;
            k_next     = 2'd0;
            flag_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= GS_CONE;
            w_reg     <= 2'd0;
            r_reg     <= 2'd0;
            c_reg     <= 3'd0;
            side_reg  <= 1'b0;
            k_reg     <= 2'd0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            w_reg     <= w_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            side_reg  <= side_next;
            k_reg     <= k_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        t_reg    <= t_next;
        cone_reg <= cone_next;
        ry_reg   <= ry_next;
        a_reg    <= a_next;
        gain_reg <= gain_next;
    end

    always_comb
    begin
        gains.ready = (state_reg == GS_DONE);
        gains.flag  = flag_reg;
        for (int k = 0; k < 3; k++)
            gains.gain[k] = gain_reg[k];
    end

endmodule

`default_nettype wire

@@ design/tsca_pipe.sv @@
// ============================================================================
// tsca_pipe - seven-stage pixel datapath
// Forward matrix, per-channel gain, inverse matrix, round and saturate.
// ============================================================================
`default_nettype none

module tsca_pipe
    import tsca_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire pix_in_t   pix,
    input  wire logic      mode,
    input  wire gain_set_t gains,
    output logic           out_valid,
    output pix_out_t       res
);

    localparam int PROD1_W = COEF_W + PIX_W + 1;
    localparam int SUM1_W  = PROD1_W + 2;
    localparam int M_W     = CONE_W + GAIN_W;
    localparam int AD_W    = M_W - GAIN_FRAC_BITS;
    localparam int PROD2_W = COEF_W + AD_W;
    localparam int SUM2_W  = PROD2_W + 2;
    localparam int STAGES  = 7;

    logic [STAGES-1:0] vld_reg;

    logic [PIX_W-1:0]          px [3];
    logic signed [PROD1_W-1:0] p1_reg [3][3];
    logic signed [SUM1_W-1:0]  s1 [3];
    logic signed [63:0]        r1 [3];
    logic signed [CONE_W-1:0]  cp_reg [3];
    logic signed [M_W-1:0]     m_reg [3];
    logic signed [63:0]        r2 [3];
    logic signed [AD_W-1:0]    ad_reg [3];
    logic signed [PROD2_W-1:0] p2_reg [3][3];
    logic signed [SUM2_W-1:0]  s2_reg [3];
    logic signed [63:0]        r3 [3];
    logic signed [OUT_W-1:0]   o [3];
    logic [2:0]                sat;
    pix_out_t                  res_reg;

    assign px[0] = pix.x_in;
    assign px[1] = pix.y_in;
    assign px[2] = pix.z_in;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            s1[r] = SUM1_W'(p1_reg[r][0]) + SUM1_W'(p1_reg[r][1]) + SUM1_W'(p1_reg[r][2]);
            r1[r] = round_shift(64'(s1[r]), COEF_FRAC_BITS);
            r2[r] = round_shift(64'(m_reg[r]), GAIN_FRAC_BITS);
            r3[r] = round_shift(64'(s2_reg[r]), COEF_FRAC_BITS);
            sat[r] = 1'b1;
            if (r3[r] > OUT_MAX64)
                o[r] = OUT_W'(OUT_MAX64);
            else if (r3[r] < OUT_MIN64)
                o[r] = OUT_W'(OUT_MIN64);
            else
            begin
                o[r]   = r3[r][OUT_W-1:0];
                sat[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                p1_reg[r][c] <= coef(mode, 1'b0, 2'(r), 2'(c)) * $signed({1'b0, px[c]});
                p2_reg[r][c] <= coef(mode, 1'b1, 2'(r), 2'(c)) * ad_reg[c];
            end
            cp_reg[r] <= r1[r][CONE_W-1:0];
            m_reg[r]  <= cp_reg[r] * $signed(gains.gain[r]);
            ad_reg[r] <= r2[r][AD_W-1:0];
            s2_reg[r] <= SUM2_W'(p2_reg[r][0]) + SUM2_W'(p2_reg[r][1])
                       + SUM2_W'(p2_reg[r][2]);
        end
        res_reg.x_out      <= o[0];
        res_reg.y_out      <= o[1];
        res_reg.z_out      <= o[2];
        res_reg.range_flag <= gains.flag | (|sat);
    end

    assign out_valid = vld_reg[STAGES-1];
    assign res       = res_reg;

endmodule

`default_nettype wire

@@ design/tsca_checker.sv @@
// ============================================================================
// tsca_checker - port-level checks for the adaptation unit
// Latency, result origin and busy behavior after register writes.
// ============================================================================
`default_nettype none

module tsca_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic cfg_we
);

    // a write always forces a gain rebuild
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy)
        else $error("busy not raised after register write");

    // every accepted word later yields a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 done)
        else $error("result missing seven cycles after accept");

    // no result without an accepted word
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 7))
        else $error("result without matching accept");

    // busy only comes back because of a write
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(cfg_we))
        else $error("busy raised without register write");

endmodule

bind two_step_chromatic_adaptation_unit tsca_checker u_tsca_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cfg_we (cfg_we)
);

`default_nettype wire

@@ bench/testbench.sv @@
// ============================================================================
// testbench - self-checking bench for two_step_chromatic_adaptation_unit
// Drives pixel words through the start/busy port, predicts result words with
// an independent fixed-point model of the two-step von Kries transform or
// by hand, and checks each done strobe against the oldest expected word.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import tsca_pkg::*;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    pix_in_t              pixel;
    logic                 done;
    pix_out_t             result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    two_step_chromatic_adaptation_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // extra settling time after the last expected word when draining
    localparam int DRAIN_CYCLES = 12;
    localparam longint LIM      = (64'sd1 <<< (GAIN_FRAC_BITS + 12)) - 1;
    localparam longint NANO     = 1000000000;

    // Published matrices in units of 1e-9, [mode][fwd/inv][row][col].
    // Coefficients are derived here rather than taken from the design table.
    longint mat_nano [2][2][3][3] = '{
        '{ '{ '{ 732800000,   429600000,  -162400000},
              '{-703600000,  1697500000,     6100000},
              '{   3000000,    13600000,   983400000} },
           '{ '{1096123821,  -278869000,   182745179},
              '{ 454369042,   473533154,    72097804},
              '{  -9627609,    -5698031,  1015325640} } },
        '{ '{ '{ 401288000,   650173000,   -51461000},
              '{-250268000,  1204414000,    45854000},
              '{  -2079000,    48952000,   953127000} },
           '{ '{1862067855, -1011254631,   149186775},
              '{ 387526543,   621447442,    -8973985},
              '{ -15841499,   -34122938,  1049964437} } }
    };

    // shadow copy of the register file
    logic             cur_mode;
    logic [CFG_W-1:0] cur_src_white;
    logic [CFG_W-1:0] cur_tgt_white;
    logic [CFG_W-1:0] cur_base_white;
    logic [DEG_W-1:0] cur_src_deg;
    logic [DEG_W-1:0] cur_tgt_deg;

    pix_out_t pending_words[$];
    bit       failed;
    bit       checking;

    // one directed row: pixel, and optionally a hand-typed expected word
    typedef struct {
        pix_in_t  pix;
        bit       typed;
        pix_out_t want;
    } dir_row_t;

    // ------------------------------------------------------------------------
    // fixed-point helpers: all rounding is to nearest, ties away from zero
    // ------------------------------------------------------------------------
    function automatic longint round_shr(longint x, int s);
        longint m;
        m = (x < 0) ? -x : x;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (x < 0) ? -m : m;
    endfunction

    function automatic longint round_div(longint n, longint d);
        longint mn;
        longint md;
        longint q;
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        q  = (mn + md / 2) / md;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi, inout bit flag);
        if (v > hi)
        begin
            flag = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            flag = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // 3x3 product with Q.14 coefficients, result back in Q.8
    function automatic void cone_xform(logic mode, bit inv, input longint v[3],
                                       output longint o[3]);
        longint acc;
        longint c;
        for (int r = 0; r < 3; r++)
        begin
            acc = 0;
            for (int k = 0; k < 3; k++)
            begin
                c   = round_div(mat_nano[mode][inv][r][k] * (64'sd1 <<< COEF_FRAC_BITS), NANO);
                acc += c * v[k];
            end
            o[r] = round_shr(acc, COEF_FRAC_BITS);
        end
    endfunction

    // adaptation factor of one white for one cone channel
    function automatic longint adapt_factor(longint yw, longint cw, longint yo, longint co,
                                            longint d, inout bit flag);
        longint ry;
        longint t;
        longint a;
        if (yo == 0)
        begin
            flag = 1'b1;
            ry   = LIM;
        end
        else
            ry = sat(round_div(yw * (64'sd1 <<< GAIN_FRAC_BITS), yo), -LIM, LIM, flag);
        if (cw == 0)
        begin
            flag = 1'b1;
            t    = LIM;
        end
        else
            t = sat(round_div(ry * co, cw), -LIM, LIM, flag);
        a = round_shr(d * t, 16) + round_shr((65536 - d) * (64'sd1 <<< GAIN_FRAC_BITS), 16);
        return sat(a, -LIM, LIM, flag);
    endfunction

    // expected output word for one pixel under the current registers
    function automatic pix_out_t adapt_pixel(pix_in_t p);
        longint ws[3], wt[3], wo[3], cs[3], ct[3], co[3];
        longint px[3], cp[3], ad[3], res[3];
        longint a_src, a_tgt, g;
        bit       flag;
        pix_out_t r;
        flag = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            ws[k] = longint'(cur_src_white[20*k +: 20]);
            wt[k] = longint'(cur_tgt_white[20*k +: 20]);
            wo[k] = longint'(cur_base_white[20*k +: 20]);
        end
        px[0] = longint'(p.x_in);
        px[1] = longint'(p.y_in);
        px[2] = longint'(p.z_in);
        cone_xform(cur_mode, 0, ws, cs);
        cone_xform(cur_mode, 0, wt, ct);
        cone_xform(cur_mode, 0, wo, co);
        cone_xform(cur_mode, 0, px, cp);
        for (int k = 0; k < 3; k++)
        begin
            a_src = adapt_factor(ws[1], cs[k], wo[1], co[k], longint'(cur_src_deg), flag);
            a_tgt = adapt_factor(wt[1], ct[k], wo[1], co[k], longint'(cur_tgt_deg), flag);
            if (a_tgt == 0)
            begin
                flag = 1'b1;
                g    = LIM;
            end
            else
                g = sat(round_div(a_src * (64'sd1 <<< GAIN_FRAC_BITS), a_tgt), -LIM, LIM, flag);
            ad[k] = round_shr(cp[k] * g, GAIN_FRAC_BITS);
        end
        cone_xform(cur_mode, 1, ad, res);
        for (int k = 0; k < 3; k++)
            res[k] = sat(res[k], -8388608, 8388607, flag);
        r.x_out      = res[0][OUT_W-1:0];
        r.y_out      = res[1][OUT_W-1:0];
        r.z_out      = res[2][OUT_W-1:0];
        r.range_flag = flag;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // clock, reset, timeout
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20ns * 600000);
        $display("testbench: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result checker: every done strobe pops the oldest expected word
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pix_out_t want;
        if (checking && done)
        begin
            if (pending_words.size() == 0)
            begin
                failed = 1'b1;
                $display("%0t: unexpected result word %h", $time, result);
            end
            else
            begin
                want = pending_words.pop_front();
                if (result.x_out !== want.x_out)
                begin
                    failed = 1'b1;
                    $display("%0t: x_out expected %h actual %h", $time, want.x_out, result.x_out);
                end
                if (result.y_out !== want.y_out)
                begin
                    failed = 1'b1;
                    $display("%0t: y_out expected %h actual %h", $time, want.y_out, result.y_out);
                end
                if (result.z_out !== want.z_out)
                begin
                    failed = 1'b1;
                    $display("%0t: z_out expected %h actual %h", $time, want.z_out, result.z_out);
                end
                if (result.range_flag !== want.range_flag)
                begin
                    failed = 1'b1;
                    $display("%0t: range_flag expected %b actual %b", $time,
                             want.range_flag, result.range_flag);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus tasks
    // ------------------------------------------------------------------------

    // present one word and hold it until taken; start stays high on return
    task automatic send_word(pix_in_t p, bit typed, pix_out_t want);
        start <= 1'b1;
        pixel <= p;
        do
            @(posedge clk);
        while (busy);
        pending_words.push_back(typed ? want : adapt_pixel(p));
    endtask

    task automatic idle_for(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // wait until every expected word is back, then let the pipe settle
    task automatic drain();
        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all six registers back to back; mode/degree upper junk is masked
    task automatic load_regs(logic mode, logic [CFG_W-1:0] sw, logic [CFG_W-1:0] tw,
                             logic [CFG_W-1:0] bw, logic [DEG_W-1:0] sd,
                             logic [DEG_W-1:0] td);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'({$urandom, $urandom});
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_data  <= {junk[CFG_W-1:1], mode};
        @(posedge clk);
        cfg_index <= REG_SRC_WHITE;
        cfg_data  <= sw;
        @(posedge clk);
        cfg_index <= REG_TGT_WHITE;
        cfg_data  <= tw;
        @(posedge clk);
        cfg_index <= REG_BASE_WHITE;
        cfg_data  <= bw;
        @(posedge clk);
        cfg_index <= REG_SRC_DEG;
        cfg_data  <= {junk[CFG_W-1:DEG_W], sd};
        @(posedge clk);
        cfg_index <= REG_TGT_DEG;
        cfg_data  <= {~junk[CFG_W-1:DEG_W], td};
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_mode       = mode;
        cur_src_white  = sw;
        cur_tgt_white  = tw;
        cur_base_white = bw;
        cur_src_deg    = sd;
        cur_tgt_deg    = td;
        // let busy come up before the next word is offered
        repeat (2) @(posedge clk);
    endtask

    function automatic logic [19:0] rand_comp(logic [19:0] nominal);
        case ($urandom_range(0, 9))
            0:       return 20'h0;
            1:       return 20'hFFFFF;
            2:       return 20'($urandom);
            default: return 20'(int'(nominal) + $urandom_range(0, 8000) - 4000);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_white();
        // mostly near a daylight white, sometimes extreme or arbitrary
        return {rand_comp(20'd27873), rand_comp(20'd25600), rand_comp(20'd24332)};
    endfunction

    function automatic logic [DEG_W-1:0] rand_degree();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return DEG_FULL;
            2:       return 17'h1FFFF;
            default: return 17'($urandom);
        endcase
    endfunction

    function automatic logic [19:0] rand_field();
        case ($urandom_range(0, 5))
            0:       return 20'($urandom);
            1:       return $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
            default: return 20'($urandom_range(0, 40000));
        endcase
    endfunction

    // random traffic in bursts with random gaps, some stretches back to back
    task automatic random_traffic(int n_words);
        int       burst;
        pix_in_t  p;
        pix_out_t none;
        none  = '0;
        burst = $urandom_range(1, 24);
        for (int i = 0; i < n_words; i++)
        begin
            p.x_in = rand_field();
            p.y_in = rand_field();
            p.z_in = rand_field();
            send_word(p, 1'b0, none);
            burst--;
            if (burst == 0)
            begin
                idle_for($urandom_range(1, 9));
                burst = $urandom_range(1, 24);
            end
        end
        start <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        dir_row_t dir_rows[$];
        pix_out_t none;
        none      = '0;
        failed    = 1'b0;
        checking  = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        pixel     = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_MODE;
        cfg_data  = '0;

        // register defaults after reset
        cur_mode       = 1'b1;
        cur_src_white  = '0;
        cur_tgt_white  = '0;
        cur_base_white = '0;
        cur_src_deg    = DEG_FULL;
        cur_tgt_deg    = DEG_FULL;

        // Directed rows. At reset every white is zero, so the ratios all hit
        // the limit and range_flag is set; a black pixel must stay black.
        dir_rows.push_back('{'{20'h0, 20'h0, 20'h0}, 1'b1, '{24'h0, 24'h0, 24'h0, 1'b1}});
        dir_rows.push_back('{'{20'hFFFFF, 20'hFFFFF, 20'hFFFFF}, 1'b0, none});
        dir_rows.push_back('{'{20'hFFFFF, 20'h0, 20'h0}, 1'b0, none});
        dir_rows.push_back('{'{20'h0, 20'hFFFFF, 20'h0}, 1'b0, none});
        dir_rows.push_back('{'{20'h0, 20'h0, 20'hFFFFF}, 1'b0, none});
        dir_rows.push_back('{'{20'h1, 20'h1, 20'h1}, 1'b0, none});
        dir_rows.push_back('{'{20'd24332, 20'd25600, 20'd27873}, 1'b0, none});
        dir_rows.push_back('{'{20'hAAAAA, 20'h55555, 20'hAAAAA}, 1'b0, none});
        dir_rows.push_back('{'{20'h55555, 20'hAAAAA, 20'h55555}, 1'b0, none});
        dir_rows.push_back('{'{20'd256, 20'd256, 20'd256}, 1'b0, none});

        repeat (12) @(posedge clk);
        rst_n    <= 1'b1;
        checking  = 1'b1;
        @(posedge clk);

        // reset defaults: zero baseline Y and zero white cones
        foreach (dir_rows[i])
            send_word(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].want);
        drain();

        // Zero target factor on channel 0 in CAT02: target cone equals minus
        // the baseline cone with equal Y, and a half degree cancels it.
        load_regs(1'b0, {20'd27000, 20'd25600, 20'd24000}, {20'd86679, 20'd16384, 20'd0},
                  {20'd0, 20'd16384, 20'd0}, DEG_FULL, 17'd32768);
        for (int i = 1; i < dir_rows.size(); i++)
            send_word(dir_rows[i].pix, 1'b0, none);
        drain();

        // sane daylight pair, CAT16, full adaptation
        load_regs(1'b1, {20'd27873, 20'd25600, 20'd24332}, {20'd21120, 20'd25600, 20'd24717},
                  {20'd27873, 20'd25600, 20'd24332}, DEG_FULL, DEG_FULL);
        foreach (dir_rows[i])
            send_word(dir_rows[i].pix, 1'b0, none);
        random_traffic(200);
        drain();

        // all-ones whites, degrees at the extremes (above full included)
        load_regs(1'b0, '1, '1, '1, 17'h1FFFF, '0);
        random_traffic(150);
        drain();

        load_regs(1'b1, '1, {20'd27873, 20'd25600, 20'd24332}, '1, '0, 17'h1FFFF);
        random_traffic(150);
        drain();

        // random register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            load_regs(1'($urandom), rand_white(), rand_white(), rand_white(),
                      rand_degree(), rand_degree());
            random_traffic(170);
            drain();
        end

        if (!failed)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
